>>> sv/elfr_pkg.sv
package elfr_pkg;

  localparam int unsigned MAX_LEN_DEF = 32;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TICK_W = 24;
  localparam int unsigned BC_W   = 6;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned CIDX_W = 2;

  localparam logic [BYTE_W-1:0] START_RST   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'd125;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 24'd1000;
  localparam logic [TICK_W-1:0] TICK_MAX    = '1;
  localparam logic [BYTE_W-1:0] ESC_OFFSET  = 8'd32;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_ERROR    = 3'd2,
    KIND_LOST     = 3'd3,
    KIND_RESTORED = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_START = 2'd1,
    ERR_IN_FRAME = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_START   = 2'd0,
    CFG_ESCAPE  = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_idx_e;

  // Results owed for one transaction, in emission order.
  typedef struct packed {
    logic            lost;
    err_e            err;
    logic            empty;
    logic            pay;
    logic            restore;
    logic            link_mid;  // link state after the watchdog check
    logic [BC_W-1:0] len;       // payload bytes to replay
  } plan_t;

endpackage

>>> sv/elfr_ram.sv
module elfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/elfr_parse.sv
module elfr_parse #(
  parameter int unsigned MaxLen = elfr_pkg::MAX_LEN_DEF,
  parameter int unsigned AddrW  = $clog2(MaxLen + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        mode_i,
  input  logic [elfr_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic [elfr_pkg::BYTE_W-1:0] start_byte_i,
  input  logic [elfr_pkg::BYTE_W-1:0] escape_byte_i,
  input  logic [elfr_pkg::TICK_W-1:0] timeout_ticks_i,
  output elfr_pkg::plan_t             plan_o,
  output logic                        has_result_o,
  output logic                        wr_en_o,
  output logic [AddrW-1:0]            wr_addr_o,
  output logic [elfr_pkg::BYTE_W-1:0] wr_data_o
);

  import elfr_pkg::*;

  localparam logic [BYTE_W-1:0] MaxLenB = BYTE_W'(MaxLen);
  localparam logic [BC_W-1:0]   MaxLenC = BC_W'(MaxLen);
  localparam logic [BC_W-1:0]   BcMax   = BC_W'(MaxLen + 1);

  logic [BC_W-1:0]   bc_q, bc_d;
  logic [BC_W-1:0]   len_q, len_d;
  logic              esc_q, esc_d;
  logic              link_q, link_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;

  logic [TICK_W-1:0] ticks_inc;
  logic              lost, link_mid, store, complete;
  logic [BYTE_W-1:0] sv, wdata;
  logic [BC_W-1:0]   idx, len_new;
  plan_t             plan;

  always_comb begin
    plan      = '0;
    bc_d      = bc_q;
    len_d     = len_q;
    esc_d     = esc_q;
    store     = 1'b0;
    sv        = rx_byte_i;
    complete  = 1'b0;
    len_new   = len_q;
    idx       = bc_q - BC_W'(1);

    // watchdog runs first, on every transaction
    ticks_inc = (mode_i && ticks_q != TICK_MAX) ? ticks_q + TICK_W'(1) : ticks_q;
    lost      = link_q && (ticks_inc > timeout_ticks_i);
    link_mid  = link_q & ~lost;
    ticks_d   = ticks_inc;
    link_d    = link_mid;

    plan.lost     = lost;
    plan.link_mid = link_mid;
    plan.err      = ERR_NONE;
    plan.len      = len_q;

    if (!mode_i) begin
      if (bc_q == '0) begin
        esc_d = 1'b0;
        if (rx_byte_i == start_byte_i) begin
          bc_d = BC_W'(1);
        end else begin
          plan.err = ERR_NO_START;
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        store = 1'b1;
        sv    = rx_byte_i + ESC_OFFSET;
      end else if (rx_byte_i == escape_byte_i) begin
        esc_d = 1'b1;
      end else if (rx_byte_i == start_byte_i) begin
        plan.err = ERR_IN_FRAME;
        bc_d     = BC_W'(1);
      end else begin
        store = 1'b1;
      end
    end

    wdata = sv;
    if (store) begin
      if (idx == '0) begin
        // length byte, clamped
        if (sv > MaxLenB) begin
          len_new  = MaxLenC;
          wdata    = MaxLenB;
          plan.err = ERR_TOO_LONG;
        end else begin
          len_new = sv[BC_W-1:0];
        end
        len_d      = len_new;
        complete   = (len_new == '0);
        plan.empty = complete;
      end else begin
        complete = (idx == len_q);
        plan.pay = complete;
      end
      if (complete) begin
        bc_d         = '0;
        ticks_d      = '0;
        link_d       = 1'b1;
        plan.restore = ~link_mid;
      end else begin
        bc_d = bc_q + BC_W'(1);
      end
    end
  end

  assign plan_o       = plan;
  assign has_result_o = plan.lost | (plan.err != ERR_NONE) | plan.empty | plan.pay |
                        plan.restore;
  assign wr_en_o      = accept_i & store;
  assign wr_addr_o    = idx[AddrW-1:0];
  assign wr_data_o    = wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q    <= '0;
      esc_q   <= 1'b0;
      link_q  <= 1'b0;
      ticks_q <= '0;
    end else if (accept_i) begin
      bc_q    <= bc_d;
      esc_q   <= esc_d;
      link_q  <= link_d;
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      len_q <= len_d;
    end
  end

  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> bc_q != '0)
    else $error("escape pending outside a frame");

  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= BcMax)
    else $error("byte count beyond frame size");

  a_restore_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && plan.restore |-> plan.pay || plan.empty)
    else $error("restore without a completed frame");

endmodule

>>> sv/elfr_emit.sv
module elfr_emit #(
  parameter int unsigned MaxLen = elfr_pkg::MAX_LEN_DEF,
  parameter int unsigned AddrW  = $clog2(MaxLen + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  elfr_pkg::plan_t             plan_i,
  output logic                        idle_o,
  output logic                        rd_en_o,
  output logic [AddrW-1:0]            rd_addr_o,
  input  logic [elfr_pkg::BYTE_W-1:0] rd_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  kind_o,
  output logic [elfr_pkg::BYTE_W-1:0] data_o,
  output logic [1:0]                  error_code_o,
  output logic                        link_up_o,
  output logic                        last_o
);

  import elfr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EMIT = 4'b0010,
    ST_RD   = 4'b0100,
    ST_PAY  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  plan_t           plan_q, plan_d;
  logic [BC_W-1:0] rd_idx_q, rd_idx_d;

  logic              ov_q, ov_d;
  kind_e             kind_q, kind_d;
  logic [BYTE_W-1:0] data_q, data_d;
  err_e              code_q, code_d;
  logic              link_q, link_d;
  logic              last_q, last_d;

  logic out_free, emit, emit_last, pay_done;

  assign out_free = ~ov_q | out_ready_i;
  assign pay_done = (rd_idx_q == plan_q.len);

  always_comb begin
    state_d   = state_q;
    plan_d    = plan_q;
    rd_idx_d  = rd_idx_q;
    ov_d      = ov_q & ~out_ready_i;
    kind_d    = kind_q;
    data_d    = data_q;
    code_d    = code_q;
    link_d    = link_q;
    last_d    = last_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    rd_en_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          plan_d   = plan_i;
          rd_idx_d = BC_W'(1);
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          data_d = '0;
          code_d = ERR_NONE;
          if (plan_q.lost) begin
            emit        = 1'b1;
            kind_d      = KIND_LOST;
            link_d      = 1'b0;
            emit_last   = (plan_q.err == ERR_NONE) & ~plan_q.empty & ~plan_q.pay &
                          ~plan_q.restore;
            plan_d.lost = 1'b0;
          end else if (plan_q.err != ERR_NONE) begin
            emit       = 1'b1;
            kind_d     = KIND_ERROR;
            code_d     = plan_q.err;
            link_d     = plan_q.link_mid;
            emit_last  = ~plan_q.empty & ~plan_q.pay & ~plan_q.restore;
            plan_d.err = ERR_NONE;
          end else if (plan_q.empty) begin
            emit         = 1'b1;
            kind_d       = KIND_EMPTY;
            link_d       = plan_q.link_mid;
            emit_last    = ~plan_q.restore;
            plan_d.empty = 1'b0;
          end else if (plan_q.pay) begin
            state_d = ST_RD;
          end else if (plan_q.restore) begin
            emit           = 1'b1;
            kind_d         = KIND_RESTORED;
            link_d         = 1'b1;
            emit_last      = 1'b1;
            plan_d.restore = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
          if (emit) begin
            ov_d   = 1'b1;
            last_d = emit_last;
            if (emit_last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_RD: begin
        rd_en_o = 1'b1;
        state_d = ST_PAY;
      end
      ST_PAY: begin
        if (out_free) begin
          ov_d   = 1'b1;
          kind_d = KIND_PAYLOAD;
          data_d = rd_data_i;
          code_d = ERR_NONE;
          link_d = plan_q.link_mid;
          last_d = pay_done & ~plan_q.restore;
          if (pay_done) begin
            plan_d.pay = 1'b0;
            state_d    = plan_q.restore ? ST_EMIT : ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + BC_W'(1);
            state_d  = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plan_q   <= plan_d;
    rd_idx_q <= rd_idx_d;
    kind_q   <= kind_d;
    data_q   <= data_d;
    code_q   <= code_d;
    link_q   <= link_d;
    last_q   <= last_d;
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign rd_addr_o    = rd_idx_q[AddrW-1:0];
  assign out_valid_o  = ov_q;
  assign kind_o       = kind_q;
  assign data_o       = data_q;
  assign error_code_o = code_q;
  assign link_up_o    = link_q;
  assign last_o       = last_q;

  a_pay_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAY |-> rd_idx_q != '0 && rd_idx_q <= plan_q.len)
    else $error("payload read index out of frame");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("new transaction while sequencer busy");

  a_restore_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && kind_q == KIND_RESTORED |-> link_q && last_q)
    else $error("restore result not final or link down");

endmodule

>>> sv/escaped_length_frame_receiver.sv
// Frame receiver for a byte-stuffed, length-prefixed serial stream with a
// link watchdog. Each input transaction is either a received byte (mode 0)
// or one time tick (mode 1). A frame is start byte, length byte, payload;
// inside a frame the escape byte makes the next byte stored as byte + 32
// (mod 256). Payload bytes go into a small frame RAM and, once the frame
// completes, are read back and presented one per result transaction, ending
// with a restored event if the link was down. Errors (missing start, start
// inside a frame, length above MaxLen - clamped) and link-lost events come
// out as single results. The last flag marks the final result of an input
// transaction. A transaction with no result is taken without holding the
// input. Otherwise the input is held while the sequencer replays it: a pass
// through the emit state per discrete result, a step to start the RAM
// reads, then per payload byte a RAM read state and an output register
// state, with a restored event last if one is owed; the output stalls
// while the consumer holds ready low. The next input is taken as soon as
// the sequencer is idle, even while the final result still sits in the
// output register. No clearing pass after reset. Configuration writes go
// through cfg_we_i/cfg_idx_i/cfg_data_i (0 start byte, 1 escape byte,
// 2 timeout ticks; other indexes ignored).
module escaped_length_frame_receiver #(
  parameter int unsigned MaxLen = elfr_pkg::MAX_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [elfr_pkg::BYTE_W-1:0] rx_byte_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  kind_o,
  output logic [elfr_pkg::BYTE_W-1:0] data_o,
  output logic [1:0]                  error_code_o,
  output logic                        link_up_o,
  output logic                        last_o,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [elfr_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [elfr_pkg::CFG_W-1:0]  cfg_data_i
);

  import elfr_pkg::*;

  localparam int unsigned Depth = MaxLen + 1;  // entry 0 holds the length
  localparam int unsigned AddrW = $clog2(Depth);

  // configuration registers
  logic [BYTE_W-1:0] start_q, escape_q;
  logic [TICK_W-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= START_RST;
      escape_q  <= ESCAPE_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START:   start_q   <= cfg_data_i[BYTE_W-1:0];
        CFG_ESCAPE:  escape_q  <= cfg_data_i[BYTE_W-1:0];
        CFG_TIMEOUT: timeout_q <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  logic              accept, start, seq_idle, has_result;
  plan_t             plan;
  logic              wr_en, rd_en;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;

  // input is held off only while the sequencer replays a transaction
  assign in_ready_o = seq_idle;
  assign accept     = in_valid_i & seq_idle;
  assign start      = accept & has_result;

  elfr_parse #(
    .MaxLen (MaxLen),
    .AddrW  (AddrW)
  ) u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .mode_i          (mode_i),
    .rx_byte_i       (rx_byte_i),
    .start_byte_i    (start_q),
    .escape_byte_i   (escape_q),
    .timeout_ticks_i (timeout_q),
    .plan_o          (plan),
    .has_result_o    (has_result),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  // Frame store. Reads start only after the sequencer leaves idle, so the
  // last payload write always lands before its read-back: no bypass needed.
  elfr_ram #(
    .Width (BYTE_W),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  elfr_emit #(
    .MaxLen (MaxLen),
    .AddrW  (AddrW)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .plan_i       (plan),
    .idle_o       (seq_idle),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_o       (data_o),
    .error_code_o (error_code_o),
    .link_up_o    (link_up_o),
    .last_o       (last_o)
  );

endmodule
